[src/emcb_pkg.sv]
package emcb_pkg;

  // Field widths
  localparam int unsigned DATA_W = 64;
  localparam int unsigned IDX_W  = 29;
  localparam int unsigned STAMP_W = 32;

  // Default word memory depth
  localparam int unsigned MEM_WORDS_DEF = 8192;

  // Entries in the queue between classifier and executor
  localparam int unsigned QUEUE_DEPTH = 4;

  // Command bytes
  localparam logic [7:0] CMD_WRITE = 8'h57;
  localparam logic [7:0] CMD_READ  = 8'h52;

  localparam logic [31:0] TRAILER_MARK = 32'hDEADBEEF;
  localparam logic [7:0]  KEEP_ALL     = 8'hFF;

  // Receive / respond phase
  typedef enum logic {
    PH_RX,
    PH_TX
  } phase_t;

  // What the executor does with a queued entry
  typedef enum logic [1:0] {
    ENT_WORD,   // send data as is
    ENT_READ,   // send memory word at idx
    ENT_WRITE   // store data at idx, send nothing
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [DATA_W-1:0]  data;
    logic [IDX_W-1:0]   idx;
    logic               last;
  } entry_t;

endpackage

[src/emcb_front.sv]
module emcb_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic                               op,
  input  logic [emcb_pkg::DATA_W-1:0]        in_data,
  input  logic                               in_last,
  input  logic [emcb_pkg::STAMP_W-1:0]       read_stamp,
  input  logic [emcb_pkg::STAMP_W-1:0]       write_stamp,
  output logic                               push,
  output emcb_pkg::entry_t                   push_ent
);

  emcb_pkg::phase_t             phase, phase_next;
  logic [1:0]                   rx_count, rx_count_next;
  logic [1:0]                   tx_count, tx_count_next;
  logic [47:0]                  dest_mac, dest_mac_next;
  logic [47:0]                  source_mac, source_mac_next;
  logic [15:0]                  ether_type, ether_type_next;
  logic [7:0]                   request_tag, request_tag_next;
  logic [7:0]                   command_byte, command_byte_next;
  logic [31:0]                  byte_address, byte_address_next;
  logic [8:0]                   burst_length, burst_length_next;
  logic [emcb_pkg::IDX_W-1:0]   write_index, write_index_next;
  logic [8:0]                   write_left, write_left_next;
  logic [emcb_pkg::IDX_W-1:0]   read_index, read_index_next;
  logic [8:0]                   read_left, read_left_next;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= emcb_pkg::PH_RX;
      rx_count     <= '0;
      tx_count     <= '0;
      dest_mac     <= '0;
      source_mac   <= '0;
      ether_type   <= '0;
      request_tag  <= '0;
      command_byte <= '0;
      byte_address <= '0;
      burst_length <= '0;
      write_index  <= '0;
      write_left   <= '0;
      read_index   <= '0;
      read_left    <= '0;
    end else begin
      phase        <= phase_next;
      rx_count     <= rx_count_next;
      tx_count     <= tx_count_next;
      dest_mac     <= dest_mac_next;
      source_mac   <= source_mac_next;
      ether_type   <= ether_type_next;
      request_tag  <= request_tag_next;
      command_byte <= command_byte_next;
      byte_address <= byte_address_next;
      burst_length <= burst_length_next;
      write_index  <= write_index_next;
      write_left   <= write_left_next;
      read_index   <= read_index_next;
      read_left    <= read_left_next;
    end
  end

  // Classify each beat: update header state, emit a queue entry if work results
  always_comb begin
    phase_next        = phase;
    rx_count_next     = rx_count;
    tx_count_next     = tx_count;
    dest_mac_next     = dest_mac;
    source_mac_next   = source_mac;
    ether_type_next   = ether_type;
    request_tag_next  = request_tag;
    command_byte_next = command_byte;
    byte_address_next = byte_address;
    burst_length_next = burst_length;
    write_index_next  = write_index;
    write_left_next   = write_left;
    read_index_next   = read_index;
    read_left_next    = read_left;
    push              = 1'b0;
    push_ent.kind     = emcb_pkg::ENT_WORD;
    push_ent.data     = '0;
    push_ent.idx      = '0;
    push_ent.last     = 1'b0;

    if (accept) begin
      case (phase)
        emcb_pkg::PH_RX: begin
          if (!op) begin
            case (rx_count)
              2'd0: begin
                dest_mac_next          = in_data[47:0];
                source_mac_next[15:0]  = in_data[63:48];
                rx_count_next          = 2'd1;
              end
              2'd1: begin
                source_mac_next[47:16] = in_data[31:0];
                ether_type_next        = in_data[47:32];
                request_tag_next       = in_data[55:48];
                command_byte_next      = in_data[63:56];
                rx_count_next          = 2'd2;
              end
              2'd2: begin
                byte_address_next = in_data[31:0];
                burst_length_next = in_data[40:32];
                write_index_next  = in_data[31:3];
                read_index_next   = in_data[31:3];
                write_left_next   = in_data[40:32];
                read_left_next    = in_data[40:32];
                rx_count_next     = 2'd3;
              end
              default: begin
                // Payload beat: store while the burst lasts, drop the rest
                if (command_byte == emcb_pkg::CMD_WRITE && write_left != '0) begin
                  push             = 1'b1;
                  push_ent.kind    = emcb_pkg::ENT_WRITE;
                  push_ent.data    = in_data;
                  push_ent.idx     = write_index;
                  write_index_next = write_index + 1'b1;
                  write_left_next  = write_left - 1'b1;
                end
              end
            endcase
            if (in_last) begin
              rx_count_next = 2'd0;
              phase_next    = emcb_pkg::PH_TX;
            end
          end
        end
        emcb_pkg::PH_TX: begin
          if (op) begin
            push = 1'b1;
            case (tx_count)
              2'd0: begin
                push_ent.data = {dest_mac[15:0], source_mac};
                tx_count_next = 2'd1;
              end
              2'd1: begin
                push_ent.data = {command_byte, request_tag, ether_type, dest_mac[47:16]};
                tx_count_next = 2'd2;
              end
              2'd2: begin
                push_ent.data = {23'b0, burst_length, byte_address};
                tx_count_next = 2'd3;
              end
              default: begin
                if (command_byte == emcb_pkg::CMD_READ && read_left != '0) begin
                  push_ent.kind   = emcb_pkg::ENT_READ;
                  push_ent.idx    = read_index;
                  read_index_next = read_index + 1'b1;
                  read_left_next  = read_left - 1'b1;
                end else begin
                  // Trailer ends the response
                  push_ent.data = {emcb_pkg::TRAILER_MARK,
                                   (command_byte == emcb_pkg::CMD_READ) ? read_stamp
                                                                         : write_stamp};
                  push_ent.last = 1'b1;
                  tx_count_next = 2'd0;
                  phase_next    = emcb_pkg::PH_RX;
                end
              end
            endcase
          end
        end
        default: begin
          phase_next = emcb_pkg::PH_RX;
        end
      endcase
    end
  end

endmodule

[src/emcb_fifo.sv]
module emcb_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  emcb_pkg::entry_t  push_ent,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output emcb_pkg::entry_t  pop_ent
);

  localparam int unsigned PTR_W = $clog2(emcb_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(emcb_pkg::QUEUE_DEPTH + 1);

  emcb_pkg::entry_t  slots [emcb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == CNT_W'(emcb_pkg::QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_ent   = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(emcb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(emcb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_ent;
    end
  end

endmodule

[src/emcb_back.sv]
module emcb_back #(
  parameter int unsigned MEM_WORDS = emcb_pkg::MEM_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  emcb_pkg::entry_t             q_ent,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [emcb_pkg::DATA_W-1:0]  out_data,
  output logic                         out_last
);

  localparam int unsigned AW   = $clog2(MEM_WORDS);
  localparam int unsigned IW   = emcb_pkg::IDX_W;
  // Reciprocal for idx / MEM_WORDS; the estimate is low by at most one
  localparam int unsigned SHIFT = IW + AW;
  localparam longint unsigned RECIP = (64'd1 << SHIFT) / MEM_WORDS;
  localparam logic [IW:0]     RECIP_C = RECIP[IW:0];
  localparam logic [IW-1:0]   MODULUS = IW'(MEM_WORDS);

  logic [emcb_pkg::DATA_W-1:0] mem [MEM_WORDS];

  logic                        advance;
  logic                        st1_vld, st2_vld, st3_vld, st4_vld;
  emcb_pkg::entry_t            st1_ent, st2_ent, st3_ent, st4_ent;
  logic [IW-1:0]               st1_q;
  logic [IW-1:0]               st2_p;
  logic [AW-1:0]               st3_slot;
  logic [emcb_pkg::DATA_W-1:0] rd_data;
  logic [2*IW:0]               quot_prod;
  logic [IW-1:0]               rem_raw;
  logic [IW-1:0]               rem_fix;

  // Whole pipeline moves when the output register can take a beat
  assign advance = !out_valid || out_ready;
  assign q_pop   = advance && q_valid;

  // Word slot = idx mod MEM_WORDS, over three stages
  assign quot_prod = (2*IW+1)'(q_ent.idx) * (2*IW+1)'(RECIP_C);
  assign rem_raw   = st2_ent.idx - st2_p;
  assign rem_fix   = (rem_raw >= MODULUS) ? rem_raw - MODULUS : rem_raw;

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      st1_vld   <= 1'b0;
      st2_vld   <= 1'b0;
      st3_vld   <= 1'b0;
      st4_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      st1_vld   <= q_valid;
      st2_vld   <= st1_vld;
      st3_vld   <= st2_vld;
      st4_vld   <= st3_vld;
      out_valid <= st4_vld && (st4_ent.kind != emcb_pkg::ENT_WRITE);
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (advance) begin
      st1_ent  <= q_ent;
      st1_q    <= IW'(quot_prod >> SHIFT);
      st2_ent  <= st1_ent;
      st2_p    <= IW'(st1_q * MODULUS);
      st3_ent  <= st2_ent;
      st3_slot <= AW'(rem_fix);
      st4_ent  <= st3_ent;
      out_data <= (st4_ent.kind == emcb_pkg::ENT_READ) ? rd_data : st4_ent.data;
      out_last <= st4_ent.last;
    end
  end

  // Word memory: write and registered read, in queue order
  always_ff @(posedge clk) begin
    if (advance) begin
      if (st3_vld && st3_ent.kind == emcb_pkg::ENT_WRITE) begin
        mem[st3_slot] <= st3_ent.data;
      end
      rd_data <= mem[st3_slot];
    end
  end

endmodule

[src/ethernet_memory_command_bridge.sv]
// Ethernet memory command bridge. Request frames arrive as 64-bit beats with
// tuser low; the first three beats give MACs, ethertype, tag, command, byte
// address and burst length, and for a 'W' command the following beats are
// stored in a local word memory (word index = address / 8, wrapping at
// MEM_WORDS). The beat with tlast switches to the response phase, in which
// each beat with tuser high asks for one response word: MAC-swapped header,
// address/length word, read data for an 'R' command, then a trailer holding
// the chosen timestamp and 0xDEADBEEF, sent with tlast. Beats that do not fit
// the current phase are consumed without effect. One beat is accepted every
// cycle while the four-entry command queue has room; a response word passes
// through the queue, three stages of memory index reduction, memory access and
// the output register. The output side backpressures the queue only. Reading
// a memory word never written returns undefined data.
module ethernet_memory_command_bridge #(
  parameter int unsigned MEM_WORDS = emcb_pkg::MEM_WORDS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [127:0]  s_axis_tdata,   // in_data[63:0], read_stamp[95:64], write_stamp[127:96]
  input  logic          s_axis_tlast,
  input  logic          s_axis_tuser,   // op
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [71:0]   m_axis_tdata,   // out_data[63:0], out_keep[71:64]
  output logic          m_axis_tlast
);

  logic              q_full;
  logic              push;
  emcb_pkg::entry_t  push_ent;
  logic              q_valid;
  logic              q_pop;
  emcb_pkg::entry_t  q_ent;
  logic [63:0]       out_data;

  assign s_axis_tready = !q_full;
  assign m_axis_tdata  = {emcb_pkg::KEEP_ALL, out_data};

  emcb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (s_axis_tvalid && s_axis_tready),
    .op          (s_axis_tuser),
    .in_data     (s_axis_tdata[63:0]),
    .in_last     (s_axis_tlast),
    .read_stamp  (s_axis_tdata[95:64]),
    .write_stamp (s_axis_tdata[127:96]),
    .push        (push),
    .push_ent    (push_ent)
  );

  emcb_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_ent  (push_ent),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_ent   (q_ent)
  );

  emcb_back #(
    .MEM_WORDS (MEM_WORDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ent     (q_ent),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data),
    .out_last  (m_axis_tlast)
  );

endmodule

[src/emcb_checker.sv]
module emcb_checker (
  input logic          clk,
  input logic          rst,
  input logic          m_axis_tvalid,
  input logic          m_axis_tready,
  input logic [71:0]   m_axis_tdata,
  input logic          m_axis_tlast
);

  // Stalled response beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("response beat changed while stalled");

  // Byte enables are always full
  a_keep: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[71:64] == emcb_pkg::KEEP_ALL)
    else $error("keep not all ones");

  // Every frame end carries the trailer mark
  a_trailer: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[63:32] == emcb_pkg::TRAILER_MARK)
    else $error("last beat without trailer mark");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("response beat right after reset");

endmodule

bind ethernet_memory_command_bridge emcb_checker u_emcb_checker (.*);

[verif/ethernet_memory_command_bridge_tb.sv]
module ethernet_memory_command_bridge_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MEM_WORDS = emcb_pkg::MEM_WORDS_DEF;
  localparam int SLOT_W = $clog2(MEM_WORDS);

  // beat kinds on tuser
  localparam logic OP_WORD = 1'b0;
  localparam logic OP_SLOT = 1'b1;

  // word positions in the request and in the response
  localparam int W_MAC  = 0;
  localparam int W_TYPE = 1;
  localparam int W_ADDR = 2;

  localparam int SINK_HOLD   = 300;
  localparam int WATCHDOG    = 2000;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [63:0] data;
    logic [7:0]  keep;
    logic        last;
  } resp_word_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;   // in_data[63:0], read_stamp[95:64], write_stamp[127:96]
  logic         s_axis_tlast = 1'b0;
  logic         s_axis_tuser = 1'b0; // op
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;        // out_data[63:0], out_keep[71:64]
  logic         m_axis_tlast;

  ethernet_memory_command_bridge #(.MEM_WORDS(MEM_WORDS)) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // shadow of the bridge state
  emcb_pkg::phase_t ph = emcb_pkg::PH_RX;
  int          rx_pos = 0;
  int          tx_pos = 0;
  logic [47:0] dst_mac = '0;
  logic [47:0] src_mac = '0;
  logic [15:0] eth_type = '0;
  logic [7:0]  req_tag = '0;
  logic [7:0]  cmd_reg = '0;
  logic [31:0] base_addr = '0;
  logic [8:0]  burst_len = '0;
  logic [28:0] wr_idx = '0;
  logic [8:0]  wr_left = '0;
  logic [28:0] rd_idx = '0;
  logic [8:0]  rd_left = '0;
  logic [63:0] mem_img [MEM_WORDS];
  bit          mem_set [MEM_WORDS];
  int unsigned set_slots[$];

  resp_word_t  pending_words[$];
  logic [63:0] preset_words[$];
  int          errors = 0;
  int          work_beats = 0;
  bit          steady = 1'b0;
  int          hold_seq = 0;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly back to back, sometimes a short gap, rarely a long gap
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] other_cmd();
    logic [7:0] c;
    do c = 8'($urandom); while (c == emcb_pkg::CMD_WRITE || c == emcb_pkg::CMD_READ);
    return c;
  endfunction

  // byte address with random upper and lower bits mapping onto a memory slot
  function automatic logic [31:0] addr_for_slot(input int unsigned slot);
    logic [31:0] a;
    a = $urandom;
    a[SLOT_W+2:3] = slot[SLOT_W-1:0];
    return a;
  endfunction

  function automatic bit range_written(input logic [28:0] idx, input int n);
    for (int k = 0; k < n; k++)
      if (!mem_set[SLOT_W'((int'(idx) + k) % MEM_WORDS)]) return 1'b0;
    return 1'b1;
  endfunction

  // expected effect of one accepted beat; queues the response word if any
  task automatic predict_response(input logic op, input logic [63:0] d, input logic lst,
                                  input logic [31:0] rstamp, input logic [31:0] wstamp);
    resp_word_t w;
    int s;
    if (ph == emcb_pkg::PH_RX) begin
      if (op == OP_WORD) begin
        case (rx_pos)
          W_MAC: begin
            dst_mac = d[47:0];
            src_mac[15:0] = d[63:48];
            rx_pos = W_TYPE;
          end
          W_TYPE: begin
            src_mac[47:16] = d[31:0];
            eth_type = d[47:32];
            req_tag = d[55:48];
            cmd_reg = d[63:56];
            rx_pos = W_ADDR;
          end
          W_ADDR: begin
            base_addr = d[31:0];
            burst_len = d[40:32];
            wr_idx = d[31:3];
            rd_idx = d[31:3];
            wr_left = d[40:32];
            rd_left = d[40:32];
            rx_pos = W_ADDR + 1;
          end
          default: begin
            if (cmd_reg == emcb_pkg::CMD_WRITE && wr_left != 0) begin
              s = int'(wr_idx % MEM_WORDS);
              mem_img[SLOT_W'(s)] = d;
              if (!mem_set[SLOT_W'(s)]) set_slots.push_back(s);
              mem_set[SLOT_W'(s)] = 1'b1;
              wr_idx = wr_idx + 1'b1;
              wr_left = wr_left - 1'b1;
            end
          end
        endcase
        if (lst) begin
          rx_pos = W_MAC;
          ph = emcb_pkg::PH_TX;
        end
      end
    end else if (op == OP_SLOT) begin
      w.keep = emcb_pkg::KEEP_ALL;
      w.last = 1'b0;
      case (tx_pos)
        W_MAC: begin
          w.data = {dst_mac[15:0], src_mac};
          tx_pos = W_TYPE;
        end
        W_TYPE: begin
          w.data = {cmd_reg, req_tag, eth_type, dst_mac[47:16]};
          tx_pos = W_ADDR;
        end
        W_ADDR: begin
          w.data = {23'd0, burst_len, base_addr};
          tx_pos = W_ADDR + 1;
        end
        default: begin
          if (cmd_reg == emcb_pkg::CMD_READ && rd_left != 0) begin
            w.data = mem_img[SLOT_W'(rd_idx % MEM_WORDS)];
            rd_idx = rd_idx + 1'b1;
            rd_left = rd_left - 1'b1;
          end else begin
            w.data = {emcb_pkg::TRAILER_MARK,
                      (cmd_reg == emcb_pkg::CMD_READ) ? rstamp : wstamp};
            w.last = 1'b1;
            tx_pos = W_MAC;
            ph = emcb_pkg::PH_RX;
          end
        end
      endcase
      pending_words.push_back(w);
    end
  endtask

  // offer one beat, wait for it to be taken, then maybe leave a gap
  task automatic send_beat(input logic op, input logic [63:0] d, input logic lst);
    logic [31:0] rstamp, wstamp;
    int gap;
    rstamp = $urandom;
    wstamp = $urandom;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {wstamp, rstamp, d};
    s_axis_tlast <= lst;
    do @(posedge clk); while (!s_axis_tready);
    if ((ph == emcb_pkg::PH_RX) == (op == OP_WORD)) work_beats++;
    predict_response(op, d, lst, rstamp, wstamp);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  // read range inside memory already written
  task automatic pick_read(output logic [31:0] addr, output logic [8:0] len);
    int unsigned s, run, cap;
    if (set_slots.size() == 0) begin
      addr = $urandom;
      len = '0;
      return;
    end
    s = set_slots[$urandom_range(0, set_slots.size() - 1)];
    cap = ($urandom_range(0, 29) == 0) ? 511 : 24;
    run = 0;
    while (run < cap && mem_set[SLOT_W'((s + run) % MEM_WORDS)]) run++;
    len = ($urandom_range(0, 9) == 0) ? 9'd0 : 9'($urandom_range(1, run));
    addr = addr_for_slot(s);
  endtask

  // one request frame followed by its whole response
  task automatic run_frame(input logic [7:0] cmd_b, input logic [31:0] addr,
                           input logic [8:0] len, input int n_hdr, input int n_data,
                           input int noise_pct);
    logic [47:0] dm, sm;
    logic [15:0] et;
    logic [7:0]  tg, eff_cmd;
    logic [22:0] pad;
    logic [63:0] w;
    int total;
    dm = 48'(rand64());
    sm = 48'(rand64());
    et = 16'($urandom);
    tg = 8'($urandom);
    pad = 23'($urandom);
    if (n_hdr < 3) n_data = 0;
    // never let a read reach a word that was not written
    eff_cmd = (n_hdr >= 2) ? cmd_b : cmd_reg;
    if (eff_cmd == emcb_pkg::CMD_READ) begin
      if ((n_hdr >= 3) ? !range_written(addr[31:3], int'(len))
                       : !range_written(rd_idx, int'(rd_left))) begin
        cmd_b = other_cmd();
        if (n_hdr < 2) n_hdr = 2;
      end
    end
    total = n_hdr + n_data;
    for (int i = 0; i < total; i++) begin
      case (i)
        W_MAC:   w = {sm[15:0], dm};
        W_TYPE:  w = {cmd_b, tg, et, sm[47:16]};
        W_ADDR:  w = {pad, len, addr};
        default: w = (preset_words.size() != 0) ? preset_words.pop_front() : rand64();
      endcase
      if ($urandom_range(0, 99) < noise_pct)
        send_beat(OP_SLOT, rand64(), 1'($urandom_range(0, 1)));
      send_beat(OP_WORD, w, i == total - 1);
    end
    while (ph == emcb_pkg::PH_TX) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_beat(OP_WORD, rand64(), 1'($urandom_range(0, 1)));
      send_beat(OP_SLOT, rand64(), 1'($urandom_range(0, 1)));
    end
  endtask

  // write across the top of the index space, then read it back
  task automatic test_wrap_write_read();
    preset_words = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'hA5A5_5A5A_0F0F_F0F0,
                     64'h8000_0000_0000_0001};
    run_frame(emcb_pkg::CMD_WRITE, 32'hFFFF_FFF8, 9'd3, 3, 4, 50);
    run_frame(emcb_pkg::CMD_READ, 32'hFFFF_FFFF, 9'd3, 3, 0, 50);
  endtask

  task automatic test_short_and_odd_frames();
    logic [31:0] a;
    a = addr_for_slot(100);
    run_frame(emcb_pkg::CMD_WRITE, a, 9'd3, 3, 3, 30);
    // two-word read: address and length carry over from the write
    run_frame(emcb_pkg::CMD_READ, 32'd0, 9'd0, 2, 0, 30);
    // one-word frame: read command kept, nothing left to read
    run_frame(emcb_pkg::CMD_READ, 32'd0, 9'd0, 1, 0, 30);
    // unknown command, data dropped
    run_frame(other_cmd(), $urandom, 9'd511, 3, 2, 30);
    // longest write cut short by the frame end
    run_frame(emcb_pkg::CMD_WRITE, addr_for_slot(200), 9'd511, 3, 2, 30);
    // zero-length write, data dropped
    run_frame(emcb_pkg::CMD_WRITE, addr_for_slot(300), 9'd0, 3, 2, 30);
  endtask

  // sink holds off during a long read so the queue fills and input stalls
  task automatic test_output_stall();
    logic [31:0] a;
    a = addr_for_slot($urandom_range(2048, 4095));
    run_frame(emcb_pkg::CMD_WRITE, a, 9'd16, 3, 16, 0);
    steady <= 1'b1;
    hold_seq <= hold_seq + 1;
    run_frame(emcb_pkg::CMD_READ, a, 9'd16, 3, 0, 0);
    steady <= 1'b0;
    hold_until_drained();
  endtask

  task automatic test_random_frames(input int target);
    int first, kind, n_data, noise;
    logic [31:0] a;
    logic [8:0] len;
    first = work_beats;
    while (work_beats - first < target) begin
      if ($urandom_range(0, 9) == 0) steady <= ~steady;
      noise = ($urandom_range(0, 3) == 0) ? 15 : 0;
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        a = addr_for_slot(($urandom_range(0, 1) == 0) ? $urandom_range(0, 1023)
                                                     : $urandom_range(0, MEM_WORDS - 1));
        if ($urandom_range(0, 49) == 0) begin
          len = 9'($urandom_range(256, 511));
          n_data = $urandom_range(0, 20);
        end else begin
          len = 9'($urandom_range(0, 12));
          kind = $urandom_range(0, 9);
          if (kind < 7) n_data = int'(len);
          else if (kind < 9) n_data = $urandom_range(0, len);
          else n_data = int'(len) + $urandom_range(1, 3);
        end
        run_frame(emcb_pkg::CMD_WRITE, a, len, 3, n_data, noise);
      end else if (kind < 80) begin
        pick_read(a, len);
        n_data = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        run_frame(emcb_pkg::CMD_READ, a, len, 3, n_data, noise);
      end else if (kind < 90) begin
        run_frame(other_cmd(), $urandom, 9'($urandom), 3, $urandom_range(0, 3), noise);
      end else begin
        case ($urandom_range(0, 2))
          0: run_frame(emcb_pkg::CMD_WRITE, $urandom, 9'($urandom),
                       $urandom_range(1, 2), 0, noise);
          1: run_frame(emcb_pkg::CMD_READ, $urandom, 9'($urandom),
                       $urandom_range(1, 2), 0, noise);
          default: run_frame(other_cmd(), $urandom, 9'($urandom),
                             $urandom_range(1, 2), 0, noise);
        endcase
      end
      if ($urandom_range(0, 9) == 0) hold_until_drained();
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_wrap_write_read();
    test_short_and_odd_frames();
    test_output_stall();
    test_random_frames(1400);
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin : sink
    int hold_left, idle_left, taken;
    hold_left = 0;
    idle_left = 0;
    taken = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != taken) begin
        taken = hold_seq;
        hold_left = SINK_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (steady || idle_left == 0) begin
        m_axis_tready <= 1'b1;
        idle_left = steady ? 0 : pick_gap();
      end else begin
        idle_left--;
        m_axis_tready <= 1'b0;
      end
    end
  end

  // compare each response beat with the oldest expected word
  always @(posedge clk) begin : check
    resp_word_t exp_w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected response beat, actual data %h keep %h last %b",
                 $time, m_axis_tdata[63:0], m_axis_tdata[71:64], m_axis_tlast);
      end else begin
        exp_w = pending_words.pop_front();
        if (m_axis_tdata[63:0] !== exp_w.data) begin
          errors++;
          $display("%0t: out_data expected %h, actual %h", $time, exp_w.data,
                   m_axis_tdata[63:0]);
        end
        if (m_axis_tdata[71:64] !== exp_w.keep) begin
          errors++;
          $display("%0t: out_keep expected %h, actual %h", $time, exp_w.keep,
                   m_axis_tdata[71:64]);
        end
        if (m_axis_tlast !== exp_w.last) begin
          errors++;
          $display("%0t: out_last expected %b, actual %b", $time, exp_w.last, m_axis_tlast);
        end
      end
    end
  end

  // end the run if no beat moves on either side for too long
  int quiet_cycles = 0;
  always @(posedge clk) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
      $display("status: fail");
      $finish;
    end
  end

endmodule
